FILE: rtl/kwm_pkg.sv
package kwm_pkg;

	localparam int NUM_SOURCES = 16;
	localparam int IDX_W = $clog2(NUM_SOURCES);
	// Counts up to the live limit; wide enough for the 5-bit register as well
	localparam int CNT_W = ($clog2(NUM_SOURCES + 1) > 5) ? $clog2(NUM_SOURCES + 1) : 5;
	// Live limit saturates at the source count and at the reach of the 4-bit source field
	localparam int LIM_MAX = (NUM_SOURCES < 16) ? NUM_SOURCES : 16;

	localparam int SRC_W = 4;
	localparam int VAL_W = 64;
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic apply;
		logic scan_start;
		logic scan_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic any_await;
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/k_way_merge.sv
// A word that completes a merge step gives its result through the CHECK, SCAN and EMIT
// states and the output register, and EMIT waits while the output is still held; the
// scan visits one head per cycle on a single 64-bit comparator. No new word is taken
// until the result is emitted, or until CHECK ends when another source awaits a refill.
// Reset (arst_n, asynchronous): all heads invalid, all sources awaiting refill,
// none ended, done cleared, cfg_q set to 16; head values stay undefined.
module k_way_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [kwm_pkg::CFG_W-1:0]          cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [kwm_pkg::SRC_W-1:0]          source,
	input  logic signed [kwm_pkg::VAL_W-1:0]   value,
	input  logic                               at_end,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [kwm_pkg::VAL_W-1:0]   value_res,
	output logic [kwm_pkg::SRC_W-1:0]          source_res,
	output logic                               merge_done
);
	import kwm_pkg::*;

	cmd_t             cmd;
	status_t          status;
	logic [CNT_W-1:0] live_lim;

	kwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	kwm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.source      (source),
		.value       (value),
		.at_end      (at_end),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value_res   (value_res),
		.source_res  (source_res),
		.merge_done  (merge_done),
		.live_lim    (live_lim)
	);

	// done word carries zero payload
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && merge_done |-> value_res == '0 && source_res == '0)
		else $error("done word with non-zero payload");

	// a value word names a source below the live limit
	a_src_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !merge_done |-> CNT_W'(source_res) < live_lim)
		else $error("result from a source beyond the live limit");

	// nothing follows the done word
	a_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && merge_done |=> !out_valid)
		else $error("word emitted after done");

	// emit only when the output register is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result overwritten before it was taken");

endmodule

FILE: rtl/kwm_ctrl.sv
module kwm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  kwm_pkg::status_t status,
	output kwm_pkg::cmd_t    cmd
);
	import kwm_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.apply = 1'b1;
					// after done every word is dropped
					if (!status.done) begin
						state_nxt = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (status.any_await) begin
					state_nxt = ST_IDLE;
				end else begin
					cmd.scan_start = 1'b1;
					state_nxt      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// hold until the output register can take the word
				if (status.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/kwm_datapath.sv
module kwm_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [kwm_pkg::CFG_W-1:0]          cfg_wr_data,
	input  logic [kwm_pkg::SRC_W-1:0]          source,
	input  logic signed [kwm_pkg::VAL_W-1:0]   value,
	input  logic                               at_end,
	input  kwm_pkg::cmd_t                      cmd,
	output kwm_pkg::status_t                   status,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [kwm_pkg::VAL_W-1:0]   value_res,
	output logic [kwm_pkg::SRC_W-1:0]          source_res,
	output logic                               merge_done,
	output logic [kwm_pkg::CNT_W-1:0]          live_lim
);
	import kwm_pkg::*;

	logic [VAL_W-1:0]       head_q [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] valid_q;
	logic [NUM_SOURCES-1:0] await_q;
	logic [NUM_SOURCES-1:0] ended_q;
	logic                   done_q;
	logic [CFG_W-1:0]       cfg_q;

	logic [IDX_W-1:0]       scan_idx_q;
	logic                   found_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [VAL_W-1:0]       best_val_q;

	logic                   out_valid_q;
	logic [VAL_W-1:0]       out_val_q;
	logic [SRC_W-1:0]       out_src_q;
	logic                   out_done_q;

	logic [CNT_W-1:0]       cfg_ext;
	logic [CNT_W-1:0]       lim;
	logic [NUM_SOURCES-1:0] live;
	logic [CNT_W-1:0]       src_ext;
	logic [IDX_W-1:0]       src_idx;
	logic                   src_live;
	logic [VAL_W-1:0]       cur_val;
	logic                   take;

	assign cfg_ext = CNT_W'(cfg_q);
	assign lim     = (cfg_ext > CNT_W'(LIM_MAX)) ? CNT_W'(LIM_MAX) : cfg_ext;

	always_comb begin
		for (int i = 0; i < NUM_SOURCES; i++) begin
			live[i] = (CNT_W'(i) < lim) && !ended_q[i];
		end
	end

	assign src_ext  = CNT_W'(source);
	assign src_idx  = src_ext[IDX_W-1:0];
	// src_ext < lim keeps src_idx inside the array
	assign src_live = (src_ext < lim) && !ended_q[src_idx];

	// one shared comparator, one head per scan cycle
	assign cur_val = head_q[scan_idx_q];
	assign take    = live[scan_idx_q] && valid_q[scan_idx_q] &&
			 (!found_q || ($signed(cur_val) < $signed(best_val_q)));

	assign status.done      = done_q;
	assign status.any_await = |(live & await_q);
	assign status.scan_last = (scan_idx_q == IDX_W'(NUM_SOURCES - 1));
	assign status.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			await_q     <= '1;
			ended_q     <= '0;
			done_q      <= 1'b0;
			cfg_q       <= CFG_RESET;
			scan_idx_q  <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (cmd.apply && !done_q && src_live) begin
				if (at_end) begin
					ended_q[src_idx] <= 1'b1;
					valid_q[src_idx] <= 1'b0;
					await_q[src_idx] <= 1'b0;
				end else if (await_q[src_idx]) begin
					valid_q[src_idx] <= 1'b1;
					await_q[src_idx] <= 1'b0;
				end
			end
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (found_q) begin
					// winner must refill before the next merge step
					valid_q[best_idx_q] <= 1'b0;
					await_q[best_idx_q] <= 1'b1;
				end else begin
					done_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && !done_q && src_live && !at_end && await_q[src_idx]) begin
			head_q[src_idx] <= value;
		end
		if (cmd.scan_step && take) begin
			best_idx_q <= scan_idx_q;
			best_val_q <= cur_val;
		end
		if (cmd.emit) begin
			if (found_q) begin
				out_val_q  <= best_val_q;
				out_src_q  <= SRC_W'(best_idx_q);
				out_done_q <= 1'b0;
			end else begin
				out_val_q  <= '0;
				out_src_q  <= '0;
				out_done_q <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign value_res  = $signed(out_val_q);
	assign source_res = out_src_q;
	assign merge_done = out_done_q;
	assign live_lim   = lim;

endmodule
